>>> src/ssff_pkg.sv
// Shared constants, types and segment lookup functions for the
// seven-segment frame formatter. No dependencies.
package ssff_pkg;

  typedef logic [7:0] seg_t;

  localparam int unsigned DIGITS = 4;
  localparam int unsigned FRAME_W = 36;

  // Request codes
  localparam logic [2:0] REQ_RAW    = 3'd0;
  localparam logic [2:0] REQ_HEX    = 3'd1;
  localparam logic [2:0] REQ_UDEC   = 3'd2;
  localparam logic [2:0] REQ_SDEC   = 3'd3;
  localparam logic [2:0] REQ_CHAR   = 3'd4;
  localparam logic [2:0] REQ_UPDATE = 3'd5;

  // Configuration register indexes
  localparam logic CFG_BLANK = 1'b0;
  localparam logic CFG_LEDS  = 1'b1;

  localparam seg_t SEG_ZERO  = 8'b11111100;
  localparam seg_t SEG_MINUS = 8'b00000010;
  localparam seg_t SEG_UNDER = 8'b00010000;
  localparam seg_t SEG_BLANK = 8'h00;
  localparam seg_t SEG_DP    = 8'h01;

  // Font for 0-9 and A-Z
  function automatic seg_t seg_font(input logic [5:0] idx);
    seg_t s;
    case (idx)
      6'd0:  s = 8'hFC;
      6'd1:  s = 8'h60;
      6'd2:  s = 8'hDA;
      6'd3:  s = 8'hF2;
      6'd4:  s = 8'h66;
      6'd5:  s = 8'hB6;
      6'd6:  s = 8'hBE;
      6'd7:  s = 8'hE0;
      6'd8:  s = 8'hFE;
      6'd9:  s = 8'hE6;
      6'd10: s = 8'hEE;
      6'd11: s = 8'h3E;
      6'd12: s = 8'h9C;
      6'd13: s = 8'h7A;
      6'd14: s = 8'h9E;
      6'd15: s = 8'h8E;
      6'd16: s = 8'hF6;
      6'd17: s = 8'h6E;
      6'd18: s = 8'h60;
      6'd19: s = 8'h78;
      6'd20: s = 8'h00;
      6'd21: s = 8'h1C;
      6'd22: s = 8'hEC;
      6'd23: s = 8'h2A;
      6'd24: s = 8'h3A;
      6'd25: s = 8'hCE;
      6'd26: s = 8'h00;
      6'd27: s = 8'h0A;
      6'd28: s = 8'hB6;
      6'd29: s = 8'hE0;
      6'd30: s = 8'h7C;
      6'd34: s = 8'h76;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Returns {hit, pattern}; hit is low for codes with no mapping
  function automatic logic [8:0] char_seg(input logic [7:0] ch);
    logic [8:0] r;
    logic [7:0] off;
    r = {1'b0, SEG_BLANK};
    off = 8'h00;
    if (ch == 8'd32) begin
      r = {1'b1, SEG_BLANK};
    end else if (ch == 8'd45) begin
      r = {1'b1, SEG_MINUS};
    end else if (ch == 8'd95) begin
      r = {1'b1, SEG_UNDER};
    end else if (ch inside {[8'd48:8'd57]}) begin
      off = ch - 8'd48;
      r = {1'b1, seg_font(off[5:0])};
    end else if (ch inside {[8'd65:8'd90]}) begin
      off = ch - 8'd55;
      r = {1'b1, seg_font(off[5:0])};
    end
    return r;
  endfunction

  function automatic logic [2:0] clamp_count(input logic [2:0] c);
    return (c > 3'(DIGITS)) ? 3'(DIGITS) : c;
  endfunction

endpackage

>>> src/seven_segment_frame_formatter_core.sv
// Top level of the seven-segment frame formatter: digit store, serial
// binary-to-BCD converter, per-digit writer and frame builder. Uses ssff_pkg.

// Raw-segment and character writes finish at the accept edge and leave busy
// low. Hex writes keep busy high while they write one digit position per
// cycle. Decimal writes first run the bit-serial binary-to-BCD shift (one
// input bit per cycle) and then the digit writes. An update keeps busy high
// while it shifts one digit byte per cycle into the frame shift register, and
// the 36-bit frame is shown on out_frame with out_strobe high for exactly
// one cycle right after; the receiver cannot stall it, so it must take the
// word in that cycle. Configuration writes are always ready and belong to
// idle periods.
module seven_segment_frame_formatter_core import ssff_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_req_type,
  input  logic [15:0]         in_value,
  input  logic [2:0]          in_position,
  input  logic [2:0]          in_count,
  output logic                out_strobe,
  output logic [FRAME_W-1:0]  out_frame,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [5:0]          cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BCD   = 2'd1;
  localparam logic [1:0] ST_PUT   = 2'd2;
  localparam logic [1:0] ST_FRAME = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [15:0]        bin_r, bin_nxt;
  logic [15:0]        num_r, num_nxt;
  logic [3:0]         first_r, first_nxt;
  logic [2:0]         n_r, n_nxt;
  logic               blank_run_r, blank_run_nxt;
  logic [24:0]        frame_r, frame_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               blank_lead_r, blank_lead_nxt;
  logic [5:0]         led_mask_r, led_mask_nxt;
  seg_t               digit_r [DIGITS];
  seg_t               digit_nxt [DIGITS];

  logic [15:0] bcd_adj;
  logic [15:0] neg_mag;
  logic [2:0]  cnt_less;
  logic [8:0]  chr;
  logic [1:0]  pos_idx;
  logic [3:0]  last_pos;
  seg_t        dd;

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_frame  = out_frame_r;

  // add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bcd_adj[4*i +: 4] = (num_r[4*i +: 4] >= 4'd5) ? num_r[4*i +: 4] + 4'd3
                                                   : num_r[4*i +: 4];
    end
  end

  assign neg_mag  = 16'd0 - in_value;
  assign cnt_less = (in_count == 3'd0) ? 3'd0 : in_count - 3'd1;
  assign chr      = char_seg(in_value[7:0]);
  assign pos_idx  = cnt_r[1:0];
  assign last_pos = first_r + {1'b0, n_r};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    bin_nxt        = bin_r;
    num_nxt        = num_r;
    first_nxt      = first_r;
    n_nxt          = n_r;
    blank_run_nxt  = blank_run_r;
    frame_nxt      = frame_r;
    out_strobe_nxt = 1'b0;
    out_frame_nxt  = out_frame_r;
    blank_lead_nxt = blank_lead_r;
    led_mask_nxt   = led_mask_r;
    digit_nxt      = digit_r;
    dd             = digit_r[pos_idx];

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLANK: blank_lead_nxt = cfg_data[0];
        CFG_LEDS:  led_mask_nxt   = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cnt_nxt   = 4'd0;
          first_nxt = {1'b0, in_position};
          n_nxt     = clamp_count(in_count);
          case (in_req_type)
            REQ_RAW: begin
              if (in_position < 3'(DIGITS)) digit_nxt[in_position[1:0]] = in_value[7:0];
            end
            REQ_HEX: begin
              num_nxt   = in_value;
              state_nxt = ST_PUT;
            end
            REQ_UDEC: begin
              bin_nxt   = in_value;
              num_nxt   = 16'd0;
              state_nxt = ST_BCD;
            end
            REQ_SDEC: begin
              num_nxt   = 16'd0;
              state_nxt = ST_BCD;
              bin_nxt   = in_value;
              if (in_value[15]) begin
                bin_nxt   = neg_mag;
                first_nxt = {1'b0, in_position} + 4'd1;
                n_nxt     = clamp_count(cnt_less);
                if (in_position < 3'(DIGITS)) digit_nxt[in_position[1:0]] = SEG_MINUS;
              end
            end
            REQ_CHAR: begin
              if (in_position < 3'(DIGITS) && chr[8]) begin
                digit_nxt[in_position[1:0]] = chr[7:0];
              end
            end
            REQ_UPDATE: begin
              frame_nxt     = 25'd1;
              blank_run_nxt = blank_lead_r;
              state_nxt     = ST_FRAME;
            end
            default: ;
          endcase
        end
      end
      ST_BCD: begin
        num_nxt = {bcd_adj[14:0], bin_r[15]};
        bin_nxt = {bin_r[14:0], 1'b0};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = ST_PUT;
          cnt_nxt   = 4'd0;
        end
      end
      ST_PUT: begin
        // position p takes the nibble of weight 16^(3-p), MSB nibble first
        if ({2'b00, pos_idx} >= first_r && {2'b00, pos_idx} < last_pos) begin
          digit_nxt[pos_idx] = seg_font({2'b00, num_r[15:12]});
        end
        num_nxt = {num_r[11:0], 4'h0};
        cnt_nxt = cnt_r + 4'd1;
        if (pos_idx == 2'(DIGITS - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = 4'd0;
        end
      end
      ST_FRAME: begin
        if (blank_run_r && dd == SEG_ZERO && pos_idx != 2'(DIGITS - 1)) begin
          dd = SEG_BLANK;
        end else begin
          blank_run_nxt = 1'b0;
        end
        if (led_mask_r[{1'b0, pos_idx}]) dd = dd | SEG_DP;
        frame_nxt = {frame_r[16:0], dd};
        cnt_nxt   = cnt_r + 4'd1;
        if (pos_idx == 2'(DIGITS - 1)) begin
          out_frame_nxt  = {frame_r, dd, led_mask_r[4], led_mask_r[5], 1'b0};
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
          cnt_nxt        = 4'd0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= 4'd0;
      out_strobe_r <= 1'b0;
      blank_lead_r <= 1'b0;
      led_mask_r   <= 6'd0;
      for (int i = 0; i < DIGITS; i++) digit_r[i] <= SEG_BLANK;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      blank_lead_r <= blank_lead_nxt;
      led_mask_r   <= led_mask_nxt;
      digit_r      <= digit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r       <= bin_nxt;
    num_r       <= num_nxt;
    first_r     <= first_nxt;
    n_r         <= n_nxt;
    blank_run_r <= blank_run_nxt;
    frame_r     <= frame_nxt;
    out_frame_r <= out_frame_nxt;
  end

  a_update_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_UPDATE) |=> (busy && state_r == ST_FRAME))
    else $error("update request did not start frame build");

  a_strobe_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == ST_FRAME && !busy))
    else $error("result strobe without frame build");

  a_frame_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_frame[FRAME_W-1] && !out_frame[0]))
    else $error("frame start or stop bit wrong");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

endmodule
